// ===== rtl/scalar_kalman_multichannel_macros.svh =====
// Assertion macros shared by the scalar Kalman filter RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef SCALAR_KALMAN_MULTICHANNEL_MACROS_SVH
`define SCALAR_KALMAN_MULTICHANNEL_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SKMC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SKMC_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/skmc_pkg.sv =====
// Types and constants of the multichannel scalar Kalman filter.
// No dependencies; used by every module of the block.
package skmc_pkg;

   localparam int CHANNELS_DEF = 64;
   localparam int CHAN_W       = 6;
   localparam int CHAN_CODES   = 2 ** CHAN_W;
   localparam int NOISE_W      = 31;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 31'd655;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 31'd65536;

   localparam logic [31:0] COV_ONE  = 32'h0001_0000;
   localparam logic [16:0] GAIN_ONE = 17'h1_0000;

   // transaction kinds on req_tuser
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_RESET  = 1'b1;

   // register select, word address bit 2
   localparam logic REG_PROCESS_NOISE     = 1'b0;
   localparam logic REG_MEASUREMENT_NOISE = 1'b1;

   typedef struct packed {
      logic signed [31:0] est;
      logic        [31:0] cov;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PRED,
      S_START,
      S_DIV,
      S_MULX,
      S_MULP,
      S_DONE
   } state_type;

endpackage

// ===== rtl/skmc_div.sv =====
// Radix-2 restoring divider for the Kalman gain: floor(numer * 2^16 / denom).
// One quotient bit per cycle, 17 steps; needs numer <= denom. Uses skmc_pkg.
module skmc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] numer,
   input  logic [32:0] denom,
   output logic        done,
   output logic [16:0] quotient
);
   import skmc_pkg::*;

`include "scalar_kalman_multichannel_macros.svh"

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [16:0] bits_ff, bits_in;
   logic [16:0] quo_ff, quo_in;

   logic [33:0] trial;
   logic [33:0] trial_sub;
   logic        trial_ge;

   always_comb begin
      trial     = {rem_ff, bits_ff[16]};
      trial_ge  = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      bits_in  = bits_ff;
      quo_in   = quo_ff;

      if (start) begin
         den_in   = denom;
         rem_in   = {2'b00, numer[31:1]};
         bits_in  = {numer[0], 16'h0000};
         quo_in   = '0;
         count_in = 5'd17;
         if (denom == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = trial_ge ? trial_sub[32:0] : trial[32:0];
         quo_in   = {quo_ff[15:0], trial_ge};
         bits_in  = {bits_ff[15:0], 1'b0};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      bits_ff  <= bits_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `SKMC_ASSERT_IMP(a_start_idle, start, !busy_ff, "divider started while busy")
   `SKMC_ASSERT_IMP(a_done_not_busy, done_ff, !busy_ff, "divider done while still stepping")
   `SKMC_ASSERT_IMP(a_gain_range, done_ff, quo_ff <= GAIN_ONE, "gain above 1.0")

endmodule

// ===== rtl/skmc_store.sv =====
// Per-channel state memory: estimate and covariance of each channel.
// One write port, one registered read port. Uses skmc_pkg::entry_type.
module skmc_store #(
   parameter int CHANNELS = skmc_pkg::CHANNELS_DEF,
   parameter int ADDR_W   = 6
) (
   input  logic                clock,
   input  logic [ADDR_W-1:0]   rd_addr,
   output skmc_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  skmc_pkg::entry_type wr_data
);
   import skmc_pkg::*;

   entry_type mem [CHANNELS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/scalar_kalman_multichannel.sv =====
// Multichannel scalar Kalman filter (random walk, Q16.16). Each filter transaction on the
// req_ stream carries a channel, an observation and optional q and r overrides (negative
// selects the csr_ registers) and yields one rsp_ transaction with the new estimate; a
// reset transaction (req_tuser = 1) clears the initialized state and yields nothing.
// Until a frame has ended, a channel starts from the observation with covariance 1.0.
// One element at a time: from acceptance until its result is loaded and req_tready
// returns, a filter transaction passes through a state memory read, the 17-step
// radix-2 gain divider and two passes through one 18x34 multiplier. When P' + r is
// zero the divider answers at once, without stepping. A reset transaction is done
// when it is accepted. The result register lets the next element start while a
// result waits on rsp_tready.
// Depends on skmc_pkg, skmc_div, skmc_store and the macros header.
module scalar_kalman_multichannel #(
   parameter int CHANNELS = skmc_pkg::CHANNELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // req_tdata: channel[5:0], observation[37:6], noise_q_override[69:38],
   //            noise_r_override[101:70], zero fill[103:102]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,
   input  logic [0:0]    req_tuser,   // action
   input  logic          req_tlast,   // frame_end
   // rsp_tdata: filtered[31:0], out_channel[37:32], zero fill[39:38]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,
   output logic          rsp_tlast,   // out_frame_end
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import skmc_pkg::*;

`include "scalar_kalman_multichannel_macros.svh"

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic signed [36:0] Y_MAX = 37'sd2147483647;
   localparam logic signed [36:0] Y_MIN = -37'sd2147483648;

   state_type state_ff, state_in;

   logic               init_ff, init_in;
   logic [NOISE_W-1:0] preg_ff, preg_in;
   logic [NOISE_W-1:0] mreg_ff, mreg_in;

   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [31:0] z_ff, z_in;
   logic [NOISE_W-1:0] q_ff, q_in;
   logic [NOISE_W-1:0] r_ff, r_in;
   logic               fend_ff, fend_in;
   logic signed [31:0] x_ff, x_in;
   logic [31:0]        pp_ff, pp_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [16:0]        gain_ff, gain_in;
   logic signed [51:0] prod_ff, prod_in;
   logic signed [31:0] y_ff, y_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_filt_ff, rsp_filt_in;
   logic [CHAN_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [AW-1:0]      idx_lut [CHAN_CODES];
   logic               req_acc;
   logic               req_reset;
   logic               csr_wr;
   logic signed [31:0] req_q, req_r;

   logic               div_start;
   logic [32:0]        div_den;
   logic               div_done;
   logic [16:0]        div_quo;

   entry_type          rd_entry;
   entry_type          wr_entry;
   logic               wr_en;

   logic [31:0]        base_cov;
   logic [32:0]        pp_sum;
   logic signed [17:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [51:0] mul_p;
   logic signed [35:0] corr;
   logic signed [36:0] y_sum;

   for (genvar g = 0; g < CHAN_CODES; g++) begin : g_idx
      assign idx_lut[g] = AW'(g % CHANNELS);
   end

   assign req_acc   = req_tvalid && req_tready;
   assign req_reset = req_acc && (req_tuser[0] == ACT_RESET);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_q     = $signed(req_tdata[69:38]);
   assign req_r     = $signed(req_tdata[101:70]);

   // shared multiplier: gain * (z - x), then (1 - gain) * P'
   assign mul_p = mul_a * mul_b;
   assign corr  = $signed(prod_ff[51:16]);
   assign y_sum = $signed({{5{x_ff[31]}}, x_ff}) + $signed({corr[35], corr});

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      preg_in      = preg_ff;
      mreg_in      = mreg_ff;
      chan_in      = chan_ff;
      idx_in       = idx_ff;
      z_in         = z_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      fend_in      = fend_ff;
      x_in         = x_ff;
      pp_in        = pp_ff;
      diff_in      = diff_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_filt_in  = rsp_filt_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_den      = {1'b0, pp_ff} + {2'b00, r_ff};
      wr_en        = 1'b0;
      wr_entry.est = y_ff;
      wr_entry.cov = prod_ff[47:16];
      base_cov     = init_ff ? rd_entry.cov : COV_ONE;
      pp_sum       = {1'b0, base_cov} + {2'b00, q_ff};
      mul_a        = $signed({1'b0, gain_ff});
      mul_b        = $signed({diff_ff[32], diff_ff});

      if (csr_wr) begin
         case (csr_paddr[2])
            REG_PROCESS_NOISE:     preg_in = csr_pwdata[NOISE_W-1:0];
            REG_MEASUREMENT_NOISE: mreg_in = csr_pwdata[NOISE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0] == ACT_RESET) begin
                  init_in = 1'b0;
               end else begin
                  chan_in  = req_tdata[5:0];
                  idx_in   = idx_lut[req_tdata[5:0]];
                  z_in     = $signed(req_tdata[37:6]);
                  q_in     = req_q[31] ? preg_ff : req_q[NOISE_W-1:0];
                  r_in     = req_r[31] ? mreg_ff : req_r[NOISE_W-1:0];
                  fend_in  = req_tlast;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_PRED;
         end
         S_PRED: begin
            x_in     = init_ff ? rd_entry.est : z_ff;
            pp_in    = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
            state_in = S_START;
         end
         S_START: begin
            diff_in   = $signed({z_ff[31], z_ff}) - $signed({x_ff[31], x_ff});
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               gain_in  = (div_quo > GAIN_ONE) ? GAIN_ONE : div_quo;
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            prod_in  = mul_p;
            state_in = S_MULP;
         end
         S_MULP: begin
            mul_a   = $signed({1'b0, GAIN_ONE - gain_ff});
            mul_b   = $signed({2'b00, pp_ff});
            prod_in = mul_p;
            if (y_sum > Y_MAX) begin
               y_in = 32'sh7FFF_FFFF;
            end else if (y_sum < Y_MIN) begin
               y_in = 32'sh8000_0000;
            end else begin
               y_in = y_sum[31:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_filt_in  = y_ff;
               rsp_chan_in  = chan_ff;
               rsp_last_in  = fend_ff;
               if (fend_ff) begin
                  init_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_ff      <= 1'b0;
         preg_ff      <= PROCESS_NOISE_RST;
         mreg_ff      <= MEASUREMENT_NOISE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         preg_ff      <= preg_in;
         mreg_ff      <= mreg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chan_ff     <= chan_in;
      idx_ff      <= idx_in;
      z_ff        <= z_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      fend_ff     <= fend_in;
      x_ff        <= x_in;
      pp_ff       <= pp_in;
      diff_ff     <= diff_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      y_ff        <= y_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

   skmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (pp_ff),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   skmc_store #(
      .CHANNELS (CHANNELS),
      .ADDR_W   (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (idx_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_chan_ff, rsp_filt_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MEASUREMENT_NOISE) ? {1'b0, mreg_ff}
                                                               : {1'b0, preg_ff};

   `SKMC_ASSERT_NXT(a_reset_clears_init, req_reset, !init_ff, "reset transaction kept init set")
   `SKMC_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "stray result")
   `SKMC_ASSERT_IMP(a_div_done_in_div, div_done, state_ff == S_DIV, "gain ready outside wait")

endmodule
